[sv/sbl_pkg.sv]
// sbl_pkg: shared types, codes and defaults for the sequence boundary lookup.
// No dependencies; every other file of the block but sbl_ram refers to it by scoped names.
package sbl_pkg;

    // fixed field widths of the channels
    localparam int IDX_FIELD_W = 10;
    localparam int POS_FIELD_W = 32;
    localparam int CNT_FIELD_W = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    // parameter defaults
    localparam int MAX_SEQS_DEF    = 1024;
    localparam int POS_WIDTH_DEF   = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    // command codes on the input channel
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_OFFSET = 1'b1;

    typedef enum logic {
        K_LOAD,
        K_QUERY
    } t_kind;

    typedef enum logic [2:0] {
        B_IDLE,
        B_FIRST,
        B_CMP,
        B_LOW,
        B_EMIT
    } t_state;

    typedef struct packed {
        t_kind                  kind;
        logic [IDX_FIELD_W-1:0] load_index;
        logic [POS_FIELD_W-1:0] load_end;
        logic [POS_FIELD_W-1:0] ref_start;
        logic [POS_FIELD_W-1:0] query_start;
        logic [POS_FIELD_W-1:0] len;
        logic [POS_FIELD_W-1:0] abs_pos;
        logic                   use_ref;
    } t_entry;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0] seq_index;
        logic [POS_FIELD_W-1:0] ref_start;
        logic [POS_FIELD_W-1:0] query_start;
        logic [POS_FIELD_W-1:0] len;
        logic [POS_FIELD_W-1:0] abs_pos;
        logic                   found;
    } t_result;

    typedef struct packed {
        logic [CNT_FIELD_W-1:0] seq_count;
        logic [CFG_DATA_W-1:0]  position_offset;
    } t_cfg;

endpackage

[sv/sbl_ifs.sv]
// sbl_ifs: valid/ready channel interfaces (input, result, config write).
// Depends on sbl_pkg for the field widths.
interface sbl_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   cmd;
    logic [sbl_pkg::IDX_FIELD_W-1:0]        load_index;
    logic [sbl_pkg::POS_FIELD_W-1:0]        load_end;
    logic [sbl_pkg::POS_FIELD_W-1:0]        match_ref_start;
    logic [sbl_pkg::POS_FIELD_W-1:0]        match_query_start;
    logic [sbl_pkg::POS_FIELD_W-1:0]        match_len;
    logic [sbl_pkg::POS_FIELD_W-1:0]        match_abs_pos;
    logic                                   use_ref;

    modport source (
        output valid, cmd, load_index, load_end, match_ref_start, match_query_start,
               match_len, match_abs_pos, use_ref,
        input  ready
    );
    modport sink (
        input  valid, cmd, load_index, load_end, match_ref_start, match_query_start,
               match_len, match_abs_pos, use_ref,
        output ready
    );
endinterface

interface sbl_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [sbl_pkg::IDX_FIELD_W-1:0]        seq_index;
    logic [sbl_pkg::POS_FIELD_W-1:0]        out_ref_start;
    logic [sbl_pkg::POS_FIELD_W-1:0]        out_query_start;
    logic [sbl_pkg::POS_FIELD_W-1:0]        out_len;
    logic [sbl_pkg::POS_FIELD_W-1:0]        out_abs_pos;
    logic                                   found;

    modport source (
        output valid, seq_index, out_ref_start, out_query_start, out_len, out_abs_pos,
               found,
        input  ready
    );
    modport sink (
        input  valid, seq_index, out_ref_start, out_query_start, out_len, out_abs_pos,
               found,
        output ready
    );
endinterface

interface sbl_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [sbl_pkg::CFG_IDX_W-1:0]          index;
    logic [sbl_pkg::CFG_DATA_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/sbl_ram.sv]
// sbl_ram: generic RAM, one write port, two read ports, registered read data.
// No dependencies.
module sbl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

[sv/sbl_front.sv]
// sbl_front: input stage; takes beats, classifies load/query, drops loads
// beyond the table. Depends on sbl_pkg and sbl_in_if.
module sbl_front #(
    parameter int MAX_SEQS = sbl_pkg::MAX_SEQS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sbl_in_if.sink          i_in,
    input  logic            i_q_full,
    output logic            o_push,
    output sbl_pkg::t_entry o_entry
);

    logic            r_valid, n_valid;
    sbl_pkg::t_entry r_entry, n_entry;
    logic            s_load, s_keep, s_accept;

    assign s_load   = (i_in.cmd == sbl_pkg::CMD_LOAD);
    assign s_keep   = !s_load || (32'(i_in.load_index) < 32'(MAX_SEQS));
    assign i_in.ready = !r_valid || !i_q_full;
    assign s_accept = i_in.valid && i_in.ready;
    assign o_push   = r_valid && !i_q_full;
    assign o_entry  = r_entry;

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (s_accept && s_keep) begin
            n_valid             = 1'b1;
            n_entry.kind        = s_load ? sbl_pkg::K_LOAD : sbl_pkg::K_QUERY;
            n_entry.load_index  = i_in.load_index;
            n_entry.load_end    = i_in.load_end;
            n_entry.ref_start   = i_in.match_ref_start;
            n_entry.query_start = i_in.match_query_start;
            n_entry.len         = i_in.match_len;
            n_entry.abs_pos     = i_in.match_abs_pos;
            n_entry.use_ref     = i_in.use_ref;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

endmodule

[sv/sbl_queue.sv]
// sbl_queue: short FIFO of classified items between front and back.
// Depends on sbl_pkg for the entry type.
module sbl_queue #(
    parameter int DEPTH = sbl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sbl_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output sbl_pkg::t_entry o_entry
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    sbl_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic            s_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign s_pop   = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + PW'(1);
        end
        if (s_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !s_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && s_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

[sv/sbl_back.sv]
// sbl_back: executes loads and runs the binary search for queries; owns the
// result register. Depends on sbl_pkg, sbl_out_if; drives the table RAM ports.
module sbl_back #(
    parameter int MAX_SEQS  = sbl_pkg::MAX_SEQS_DEF,
    parameter int POS_WIDTH = sbl_pkg::POS_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbl_pkg::t_cfg               i_cfg,
    input  logic                        i_q_valid,
    input  sbl_pkg::t_entry             i_q_entry,
    output logic                        o_q_pop,
    output logic                        o_we,
    output logic [$clog2(MAX_SEQS)-1:0] o_waddr,
    output logic [POS_WIDTH-1:0]        o_wdata,
    output logic [$clog2(MAX_SEQS)-1:0] o_raddr_a,
    output logic [$clog2(MAX_SEQS)-1:0] o_raddr_b,
    input  logic [POS_WIDTH-1:0]        i_rdata_a,
    input  logic [POS_WIDTH-1:0]        i_rdata_b,
    sbl_out_if.source                   o_out
);

    localparam int IDX_W = $clog2(MAX_SEQS);
    localparam int CNT_W = $clog2(MAX_SEQS + 1);
    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

    sbl_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0] r_n, n_n, r_left, n_left, r_right, n_right, r_mid, n_mid;
    logic [POS_WIDTH-1:0] r_start, n_start;
    sbl_pkg::t_entry  r_match, n_match;
    sbl_pkg::t_result r_res, n_res, r_o, n_o, s_hit_res;
    logic             r_o_valid, n_o_valid;

    logic [CNT_W-1:0]     s_ncl, s_nl, s_nr, s_nmid, s_hit_idx;
    logic [POS_WIDTH-1:0] s_start, s_rel;
    logic                 s_lt_a, s_lt_b, s_mid_pos, s_mid_inner, s_cont, s_slot_free;
    logic                 s_q_query;

    function automatic sbl_pkg::t_result f_pass(sbl_pkg::t_entry e);
        sbl_pkg::t_result r;
        r.seq_index   = '0;
        r.ref_start   = e.ref_start;
        r.query_start = e.query_start;
        r.len         = e.len;
        r.abs_pos     = e.abs_pos;
        r.found       = 1'b1;
        return r;
    endfunction

    // sequence count: zero counts as one, saturate at table size
    always_comb begin
        if (i_cfg.seq_count == '0) begin
            s_ncl = ONE;
        end else if (32'(i_cfg.seq_count) > 32'(MAX_SEQS)) begin
            s_ncl = CNT_W'(MAX_SEQS);
        end else begin
            s_ncl = CNT_W'(i_cfg.seq_count);
        end
    end

    assign s_q_query   = i_q_valid && (i_q_entry.kind == sbl_pkg::K_QUERY);
    assign s_start     = POS_WIDTH'(i_q_entry.use_ref ? i_q_entry.ref_start
                                                      : i_q_entry.query_start)
                       + POS_WIDTH'(i_cfg.position_offset);
    assign s_lt_a      = (r_start < i_rdata_a);
    assign s_lt_b      = (r_start < i_rdata_b);
    assign s_mid_pos   = (r_mid != '0);
    assign s_mid_inner = ((r_mid + ONE) < r_n);
    assign s_rel       = r_start - i_rdata_a;
    assign s_slot_free = !r_o_valid || o_out.ready;
    assign s_hit_idx   = (r_state == sbl_pkg::B_LOW) ? r_mid : r_mid + ONE;

    // search bounds after this step
    always_comb begin
        s_nl = r_left;
        s_nr = r_right;
        case (r_state)
            sbl_pkg::B_FIRST: begin
                s_nl = '0;
                s_nr = r_n - ONE;
            end
            sbl_pkg::B_CMP: s_nl = r_mid + ONE;
            sbl_pkg::B_LOW: s_nr = r_mid - ONE;
            default: ;
        endcase
    end

    assign s_nmid = s_nl + ((s_nr - s_nl) >> 1);
    assign s_cont = (s_nl <= s_nr);

    always_comb begin
        s_hit_res.seq_index = sbl_pkg::IDX_FIELD_W'(s_hit_idx);
        s_hit_res.len       = r_match.len;
        s_hit_res.found     = 1'b1;
        if (r_match.use_ref) begin
            s_hit_res.ref_start   = 32'(s_rel);
            s_hit_res.query_start = r_match.query_start;
            s_hit_res.abs_pos     = 32'(r_start);
        end else begin
            s_hit_res.ref_start   = r_match.ref_start;
            s_hit_res.query_start = 32'(s_rel);
            s_hit_res.abs_pos     = r_match.ref_start;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbl_pkg::B_IDLE: begin
                if (s_q_query) begin
                    n_state = (s_ncl == ONE) ? sbl_pkg::B_EMIT : sbl_pkg::B_FIRST;
                end
            end
            sbl_pkg::B_FIRST: n_state = s_lt_a ? sbl_pkg::B_EMIT : sbl_pkg::B_CMP;
            sbl_pkg::B_CMP: begin
                if (s_lt_a) begin
                    n_state = s_mid_pos ? sbl_pkg::B_LOW : sbl_pkg::B_EMIT;
                end else if (s_mid_inner && s_lt_b) begin
                    n_state = sbl_pkg::B_EMIT;
                end else begin
                    n_state = s_cont ? sbl_pkg::B_CMP : sbl_pkg::B_EMIT;
                end
            end
            sbl_pkg::B_LOW: begin
                if (!s_lt_a) begin
                    n_state = sbl_pkg::B_EMIT;
                end else begin
                    n_state = s_cont ? sbl_pkg::B_CMP : sbl_pkg::B_EMIT;
                end
            end
            sbl_pkg::B_EMIT: n_state = s_slot_free ? sbl_pkg::B_IDLE : sbl_pkg::B_EMIT;
            default: n_state = sbl_pkg::B_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_q_pop   = 1'b0;
        o_we      = 1'b0;
        o_waddr   = IDX_W'(i_q_entry.load_index);
        o_wdata   = POS_WIDTH'(i_q_entry.load_end);
        o_raddr_a = '0;
        o_raddr_b = '0;
        n_n       = r_n;
        n_left    = r_left;
        n_right   = r_right;
        n_mid     = r_mid;
        n_start   = r_start;
        n_match   = r_match;
        n_res     = r_res;
        n_o_valid = r_o_valid && !o_out.ready;
        n_o       = r_o;
        case (r_state)
            sbl_pkg::B_IDLE: begin
                o_q_pop = i_q_valid;
                if (i_q_valid && (i_q_entry.kind == sbl_pkg::K_LOAD)) begin
                    o_we = 1'b1;
                end
                if (s_q_query) begin
                    n_match = i_q_entry;
                    n_n     = s_ncl;
                    n_start = s_start;
                    n_res   = f_pass(i_q_entry);
                end
            end
            sbl_pkg::B_FIRST: begin
                if (s_lt_a) begin
                    n_res = f_pass(r_match);
                end else begin
                    n_left    = s_nl;
                    n_right   = s_nr;
                    n_mid     = s_nmid;
                    o_raddr_a = IDX_W'(s_nmid);
                    o_raddr_b = IDX_W'(s_nmid + ONE);
                end
            end
            sbl_pkg::B_CMP: begin
                if (s_lt_a) begin
                    if (s_mid_pos) begin
                        o_raddr_a = IDX_W'(r_mid - ONE);
                    end else begin
                        n_res = '0;
                    end
                end else if (s_mid_inner && s_lt_b) begin
                    n_res = s_hit_res;
                end else if (s_cont) begin
                    n_left    = s_nl;
                    n_right   = s_nr;
                    n_mid     = s_nmid;
                    o_raddr_a = IDX_W'(s_nmid);
                    o_raddr_b = IDX_W'(s_nmid + ONE);
                end else begin
                    n_res = '0;
                end
            end
            sbl_pkg::B_LOW: begin
                if (!s_lt_a) begin
                    n_res = s_hit_res;
                end else if (s_cont) begin
                    n_left    = s_nl;
                    n_right   = s_nr;
                    n_mid     = s_nmid;
                    o_raddr_a = IDX_W'(s_nmid);
                    o_raddr_b = IDX_W'(s_nmid + ONE);
                end else begin
                    n_res = '0;
                end
            end
            sbl_pkg::B_EMIT: begin
                if (s_slot_free) begin
                    n_o_valid = 1'b1;
                    n_o       = r_res;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sbl_pkg::B_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_n     <= n_n;
        r_left  <= n_left;
        r_right <= n_right;
        r_mid   <= n_mid;
        r_start <= n_start;
        r_match <= n_match;
        r_res   <= n_res;
        r_o     <= n_o;
    end

    assign o_out.valid           = r_o_valid;
    assign o_out.seq_index       = r_o.seq_index;
    assign o_out.out_ref_start   = r_o.ref_start;
    assign o_out.out_query_start = r_o.query_start;
    assign o_out.out_len         = r_o.len;
    assign o_out.out_abs_pos     = r_o.abs_pos;
    assign o_out.found           = r_o.found;

endmodule

[sv/sequence_boundary_lookup_unit.sv]
// Query path: a single sequence in use goes straight to the result; a start before
// the first end is settled by the read of entry 0; otherwise a binary search of S
// steps runs (at most floor(log2 n) + 1 for n sequences in use; 11 for 1024).
// The back end takes one query at a time; loads are written as they are popped.
// Reset (i_rst_n low, synchronous): queue and result register empty,
// seq_count = 1, position_offset = 0; the end table keeps no reset value.
module sequence_boundary_lookup_unit #(
    parameter int MAX_SEQS    = sbl_pkg::MAX_SEQS_DEF,
    parameter int POS_WIDTH   = sbl_pkg::POS_WIDTH_DEF,
    parameter int QUEUE_DEPTH = sbl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sbl_cfg_if.sink   i_cfg,
    sbl_in_if.sink    i_in,
    sbl_out_if.source o_out
);

    // Structure:
    //   front  - registers each beat, tags it load or query, drops loads
    //            whose index lies past the table
    //   queue  - a few entries deep, so the front keeps taking beats while
    //            the back is busy searching
    //   back   - writes loads into the end table; for a query it reads entry
    //            0 first, then walks the binary search. Each step reads mid
    //            and mid+1 together on the two RAM ports; a step that turns
    //            downward fetches mid-1 in a further state, B_LOW. The RAM read
    //            latency sets the pace: one table access round per cycle.
    //   result - one output register in the back; the search of the next
    //            query overlaps a result that still waits to be taken.

    localparam int IDX_W = $clog2(MAX_SEQS);

    sbl_pkg::t_cfg   r_cfg;
    sbl_pkg::t_entry s_push_entry, s_q_entry;
    logic            s_push, s_q_full, s_q_valid, s_q_pop;

    logic                 s_we;
    logic [IDX_W-1:0]     s_waddr, s_raddr_a, s_raddr_b;
    logic [POS_WIDTH-1:0] s_wdata, s_rdata_a, s_rdata_b;

    // configuration registers; writes always accepted
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seq_count       <= sbl_pkg::CNT_FIELD_W'(1);
            r_cfg.position_offset <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                sbl_pkg::CFG_SEQ_COUNT:
                    r_cfg.seq_count <= i_cfg.data[sbl_pkg::CNT_FIELD_W-1:0];
                sbl_pkg::CFG_POS_OFFSET:
                    r_cfg.position_offset <= i_cfg.data;
                default: ;
            endcase
        end
    end

    sbl_front #(
        .MAX_SEQS (MAX_SEQS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (s_q_full),
        .o_push   (s_push),
        .o_entry  (s_push_entry)
    );

    sbl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_entry (s_push_entry),
        .o_full  (s_q_full),
        .i_pop   (s_q_pop),
        .o_valid (s_q_valid),
        .o_entry (s_q_entry)
    );

    // end table: one entry per sequence, exclusive end positions
    sbl_ram #(
        .WIDTH (POS_WIDTH),
        .DEPTH (MAX_SEQS)
    ) u_end_table (
        .i_clk     (i_clk),
        .i_we      (s_we),
        .i_waddr   (s_waddr),
        .i_wdata   (s_wdata),
        .i_raddr_a (s_raddr_a),
        .o_rdata_a (s_rdata_a),
        .i_raddr_b (s_raddr_b),
        .o_rdata_b (s_rdata_b)
    );

    sbl_back #(
        .MAX_SEQS  (MAX_SEQS),
        .POS_WIDTH (POS_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (s_q_valid),
        .i_q_entry (s_q_entry),
        .o_q_pop   (s_q_pop),
        .o_we      (s_we),
        .o_waddr   (s_waddr),
        .o_wdata   (s_wdata),
        .o_raddr_a (s_raddr_a),
        .o_raddr_b (s_raddr_b),
        .i_rdata_a (s_rdata_a),
        .i_rdata_b (s_rdata_b),
        .o_out     (o_out)
    );

endmodule
